// ===== src/mms_pkg.sv =====
// Shared types, codes and transition tables for the motion mode supervisor.
// No dependencies; imported by motion_mode_supervisor.
`timescale 1ns / 1ps

package mms_pkg;

  localparam int unsigned ElapsedBitsDef = 24;
  localparam int unsigned ElapsedOutW    = 24;
  localparam int unsigned ModeW          = 3;
  localparam int unsigned TicksW         = 16;
  localparam int unsigned CfgDataW       = 16;
  localparam int unsigned CfgIdxW        = 2;

  localparam logic [ModeW-1:0]  ModeMax          = 3'd4;
  localparam logic [ModeW-1:0]  DefaultModeRst   = 3'd0;
  localparam logic              SafetyEnableRst  = 1'b1;
  localparam logic [TicksW-1:0] TransTicksRst    = 16'd1000;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESET   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_SUCCESS = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOT_ALLOWED = 2'd2,
    ST_SAFETY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_STARTED   = 3'd1,
    EV_FAILED    = 3'd2,
    EV_SAFETY    = 3'd3,
    EV_CHANGED   = 3'd4,
    EV_COMPLETED = 3'd5
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEFAULT_MODE  = 2'd0,
    REG_SAFETY_ENABLE = 2'd1,
    REG_TRANS_TICKS   = 2'd2
  } cfg_reg_e;

  typedef enum logic [ModeW-1:0] {
    MODE_PASSIVE    = 3'd0,
    MODE_DAMPING    = 3'd1,
    MODE_JOINT      = 3'd2,
    MODE_STAND      = 3'd3,
    MODE_LOCOMOTION = 3'd4
  } mode_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ModeW-1:0]  req_mode;
    logic              force_flag;
    logic [TicksW-1:0] tick_count;
  } mms_in_t;

  typedef struct packed {
    logic [1:0]             status_code;
    logic [2:0]             event_code;
    logic [ModeW-1:0]       event_from_mode;
    logic [ModeW-1:0]       event_to_mode;
    logic [ModeW-1:0]       mode_now;
    logic [ModeW-1:0]       mode_before;
    logic                   in_transition;
    logic [ElapsedOutW-1:0] elapsed_out;
    logic                   last_result;
  } mms_out_t;

  // Fixed allowed-transition table: bit t of row f allows f -> t.
  function automatic logic mode_allowed(logic [ModeW-1:0] from, logic [ModeW-1:0] to);
    logic [4:0] row;
    case (from)
      MODE_PASSIVE:    row = 5'h0E;
      MODE_DAMPING:    row = 5'h0D;
      MODE_JOINT:      row = 5'h1B;
      MODE_STAND:      row = 5'h15;
      MODE_LOCOMOTION: row = 5'h0C;
      default:         row = 5'h00;
    endcase
    mode_allowed = (to <= ModeMax) ? row[to] : 1'b0;
  endfunction

  // Safety rules: from passive only damping or stand; locomotion only from
  // stand or joint.
  function automatic logic mode_safe(logic [ModeW-1:0] from, logic [ModeW-1:0] to);
    if (from == MODE_PASSIVE) begin
      mode_safe = (to == MODE_DAMPING) || (to == MODE_STAND);
    end else if (to == MODE_LOCOMOTION) begin
      mode_safe = (from == MODE_STAND) || (from == MODE_JOINT);
    end else begin
      mode_safe = 1'b1;
    end
  endfunction

endpackage

// ===== src/motion_mode_supervisor.sv =====
// Motion mode supervisor: mode state, request checks, timed transitions and
// a three-word result queue. Depends on mms_pkg.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | in_data_i  (mms_in_t)
//   out     | output    | out_valid_o/out_ready_i| out_data_o (mms_out_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One input word per cycle while ready: checks and the elapsed add-compare are one
// level of logic ahead of the result queue. A word yields one or two result words,
// which leave the queue one per cycle unless stalled. in_ready_o is high while at
// most one result waits, so a stalled output stops input after two queued results.
// Reset clears the queue and loads the reset register values; cfg is always ready.
`timescale 1ns / 1ps

module motion_mode_supervisor #(
  parameter int unsigned ELAPSED_BITS = mms_pkg::ElapsedBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mms_pkg::mms_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mms_pkg::mms_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mms_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mms_pkg::CfgDataW-1:0]   cfg_data_i
);
  import mms_pkg::*;

  localparam int unsigned QDepth = 3;

  // configuration
  logic [ModeW-1:0]  default_mode_q;
  logic              safety_en_q;
  logic [TicksW-1:0] trans_ticks_q;

  // mode state
  logic [ModeW-1:0]        cur_q, cur_d;
  logic [ModeW-1:0]        prior_q, prior_d;
  logic [ModeW-1:0]        goal_q, goal_d;
  logic                    pend_q, pend_d;
  logic [ELAPSED_BITS-1:0] elapsed_q, elapsed_d;

  // result queue
  mms_out_t   queue_q [QDepth];
  logic [1:0] head_q, tail_q;
  logic [1:0] count_q, count_d;

  logic     in_fire, out_fire;
  mms_out_t res0, res1;
  logic     two_res;

  logic [ELAPSED_BITS:0]   sum_ext;
  logic [ELAPSED_BITS-1:0] sum_sat;
  logic [ElapsedOutW-1:0]  elapsed_rep;

  function automatic logic [1:0] q_next(logic [1:0] p);
    q_next = (p == 2'(QDepth - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (count_q < 2'd2);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != 2'd0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign out_data_o  = queue_q[head_q];

  // saturating elapsed add
  assign sum_ext = {1'b0, elapsed_q} + (ELAPSED_BITS+1)'(in_data_i.tick_count);
  assign sum_sat = sum_ext[ELAPSED_BITS] ? {ELAPSED_BITS{1'b1}} : sum_ext[ELAPSED_BITS-1:0];

  generate
    if (ELAPSED_BITS > ElapsedOutW) begin : g_rep_sat
      assign elapsed_rep = (elapsed_d > ELAPSED_BITS'({ElapsedOutW{1'b1}})) ?
                           {ElapsedOutW{1'b1}} : elapsed_d[ElapsedOutW-1:0];
    end else begin : g_rep_ext
      assign elapsed_rep = ElapsedOutW'(elapsed_d);
    end
  endgenerate

  always_comb begin
    logic [1:0]       status;
    logic [2:0]       ev;
    logic [ModeW-1:0] ev_from, ev_to;
    status  = ST_SUCCESS;
    ev      = EV_NONE;
    ev_from = '0;
    ev_to   = '0;
    two_res = 1'b0;
    cur_d     = cur_q;
    prior_d   = prior_q;
    goal_d    = goal_q;
    pend_d    = pend_q;
    elapsed_d = elapsed_q;

    case (in_data_i.cmd)
      CMD_REQUEST: begin
        if (in_data_i.req_mode > ModeMax) begin
          status = ST_INVALID;
        end else if (in_data_i.req_mode == cur_q) begin
          status = ST_SUCCESS;
        end else if (!in_data_i.force_flag &&
                     !mode_allowed(cur_q, in_data_i.req_mode)) begin
          status  = ST_NOT_ALLOWED;
          ev      = EV_FAILED;
          ev_from = cur_q;
          ev_to   = in_data_i.req_mode;
        end else if (!in_data_i.force_flag && safety_en_q &&
                     !mode_safe(cur_q, in_data_i.req_mode)) begin
          status  = ST_SAFETY;
          ev      = EV_SAFETY;
          ev_from = cur_q;
          ev_to   = in_data_i.req_mode;
        end else begin
          prior_d   = cur_q;
          goal_d    = in_data_i.req_mode;
          pend_d    = 1'b1;
          elapsed_d = '0;
          ev        = EV_STARTED;
          ev_from   = cur_q;
          ev_to     = in_data_i.req_mode;
        end
      end
      CMD_TICK: begin
        if (pend_q) begin
          elapsed_d = sum_sat;
          if (sum_sat >= ELAPSED_BITS'(trans_ticks_q)) begin
            prior_d = cur_q;
            cur_d   = goal_q;
            pend_d  = 1'b0;
            two_res = 1'b1;
            ev      = EV_CHANGED;
            ev_from = cur_q;
            ev_to   = goal_q;
          end
        end
      end
      CMD_RESET: begin
        cur_d     = default_mode_q;
        prior_d   = default_mode_q;
        goal_d    = default_mode_q;
        pend_d    = 1'b0;
        elapsed_d = '0;
      end
      default: begin
      end
    endcase

    res0.status_code     = status;
    res0.event_code      = ev;
    res0.event_from_mode = ev_from;
    res0.event_to_mode   = ev_to;
    res0.mode_now        = cur_d;
    res0.mode_before     = prior_d;
    res0.in_transition   = pend_d;
    res0.elapsed_out     = elapsed_rep;
    res0.last_result     = !two_res;

    // completion word follows the mode-changed word
    res1             = res0;
    res1.event_code  = EV_COMPLETED;
    res1.last_result = 1'b1;
  end

  always_comb begin
    count_d = count_q;
    if (in_fire) begin
      count_d = count_d + (two_res ? 2'd2 : 2'd1);
    end
    if (out_fire) begin
      count_d = count_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_mode_q <= DefaultModeRst;
      safety_en_q    <= SafetyEnableRst;
      trans_ticks_q  <= TransTicksRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DEFAULT_MODE: begin
          default_mode_q <= (cfg_data_i[ModeW-1:0] > ModeMax) ? ModeMax
                                                                : cfg_data_i[ModeW-1:0];
        end
        REG_SAFETY_ENABLE: begin
          safety_en_q <= cfg_data_i[0];
        end
        REG_TRANS_TICKS: begin
          trans_ticks_q <= cfg_data_i[TicksW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= DefaultModeRst;
      prior_q   <= DefaultModeRst;
      goal_q    <= DefaultModeRst;
      pend_q    <= 1'b0;
      elapsed_q <= '0;
    end else if (in_fire) begin
      cur_q     <= cur_d;
      prior_q   <= prior_d;
      goal_q    <= goal_d;
      pend_q    <= pend_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (out_fire) begin
        head_q <= q_next(head_q);
      end
      if (in_fire) begin
        tail_q <= two_res ? q_next(q_next(tail_q)) : q_next(tail_q);
      end
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      queue_q[tail_q] <= res0;
      if (two_res) begin
        queue_q[q_next(tail_q)] <= res1;
      end
    end
  end

endmodule
